// File: rtl/inkbb_pkg.sv
`timescale 1ns / 1ps
package inkbb_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int DIST_W     = (COL_W > ROW_W) ? COL_W : ROW_W;
	localparam int DIM_W      = 13;
	localparam int THR_W      = 9;
	localparam int SCALE_W    = 24;
	localparam int MARGIN_W   = 18;
	localparam int FRAC_SHIFT = 12;
	localparam int PROD_W     = DIST_W + SCALE_W;
	localparam int VAL_W      = PROD_W - FRAC_SHIFT;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int LANES      = 4;
	localparam logic [MARGIN_W-1:0] MARGIN_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DARK_THRESHOLD = 3'd0,
		CFG_IMAGE_WIDTH    = 3'd1,
		CFG_IMAGE_HEIGHT   = 3'd2,
		CFG_SCALE_X        = 3'd3,
		CFG_SCALE_Y        = 3'd4,
		CFG_KEEP_MARGIN    = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] grey;
		logic       new_set;
	} in_t;

	typedef struct packed {
		logic [MARGIN_W-1:0] margin_left;
		logic [MARGIN_W-1:0] margin_right;
		logic [MARGIN_W-1:0] margin_top;
		logic [MARGIN_W-1:0] margin_bottom;
		logic                blank_page;
		logic [MARGIN_W-1:0] common_left;
		logic [MARGIN_W-1:0] common_right;
		logic [MARGIN_W-1:0] common_top;
		logic [MARGIN_W-1:0] common_bottom;
		logic                common_valid;
	} out_t;

	typedef struct packed {
		logic [THR_W-1:0]    dark_threshold;
		logic [DIM_W-1:0]    image_width;
		logic [DIM_W-1:0]    image_height;
		logic [SCALE_W-1:0]  scale_x;
		logic [SCALE_W-1:0]  scale_y;
		logic [MARGIN_W-1:0] keep_margin;
	} cfg_t;

	typedef struct packed {
		logic [COL_W-1:0] wm1;
		logic [ROW_W-1:0] hm1;
	} geom_t;

	typedef struct packed {
		logic             clear;
		logic             ink_found;
		logic [COL_W-1:0] left;
		logic [COL_W-1:0] right;
		logic [ROW_W-1:0] top;
		logic [ROW_W-1:0] bottom;
	} page_rec_t;

endpackage

// File: rtl/inkbb_front.sv
`timescale 1ns / 1ps
module inkbb_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  inkbb_pkg::in_t     in_data,
	input  inkbb_pkg::cfg_t    cfg,
	input  logic               fifo_full,
	output logic               push,
	output inkbb_pkg::page_rec_t rec,
	output inkbb_pkg::geom_t   geom
);
	import inkbb_pkg::*;

	logic [COL_W-1:0] column_q, left_q, right_q;
	logic [ROW_W-1:0] row_q, top_q, bottom_q;
	logic             found_q, clr_q;

	logic             accept, ink, page_end, row_end;
	logic [COL_W-1:0] left_n, right_n;
	logic [ROW_W-1:0] top_n, bottom_n;
	logic             found_n;

	// effective geometry, last column and last row index
	always_comb begin
		if (cfg.image_width == '0) begin
			geom.wm1 = '0;
		end else if (32'(cfg.image_width) > MAX_WIDTH) begin
			geom.wm1 = COL_W'(MAX_WIDTH - 1);
		end else begin
			geom.wm1 = COL_W'(cfg.image_width - 1'b1);
		end
		if (cfg.image_height == '0) begin
			geom.hm1 = '0;
		end else if (32'(cfg.image_height) > MAX_HEIGHT) begin
			geom.hm1 = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			geom.hm1 = ROW_W'(cfg.image_height - 1'b1);
		end
	end

	assign in_stall = fifo_full;
	assign accept   = in_valid && !fifo_full;
	assign ink      = {1'b0, in_data.grey} < cfg.dark_threshold;
	assign row_end  = column_q >= geom.wm1;
	assign page_end = row_end && (row_q >= geom.hm1);

	always_comb begin
		left_n   = left_q;
		right_n  = right_q;
		top_n    = top_q;
		bottom_n = bottom_q;
		found_n  = found_q;
		if (ink) begin
			found_n = 1'b1;
			if (!found_q) begin
				left_n   = column_q;
				right_n  = column_q;
				top_n    = row_q;
				bottom_n = row_q;
			end else begin
				if (column_q < left_q)  left_n   = column_q;
				if (column_q > right_q) right_n  = column_q;
				if (row_q < top_q)      top_n    = row_q;
				if (row_q > bottom_q)   bottom_n = row_q;
			end
		end
	end

	assign push          = accept && page_end;
	assign rec.clear     = clr_q || in_data.new_set;
	assign rec.ink_found = found_n;
	assign rec.left      = left_n;
	assign rec.right     = right_n;
	assign rec.top       = top_n;
	assign rec.bottom    = bottom_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
			left_q   <= '0;
			right_q  <= '0;
			top_q    <= '0;
			bottom_q <= '0;
			found_q  <= 1'b0;
			clr_q    <= 1'b0;
		end else if (accept) begin
			if (page_end) begin
				column_q <= '0;
				row_q    <= '0;
				left_q   <= '0;
				right_q  <= '0;
				top_q    <= '0;
				bottom_q <= '0;
				found_q  <= 1'b0;
				clr_q    <= 1'b0;
			end else begin
				if (row_end) begin
					column_q <= '0;
					row_q    <= row_q + 1'b1;
				end else begin
					column_q <= column_q + 1'b1;
				end
				left_q   <= left_n;
				right_q  <= right_n;
				top_q    <= top_n;
				bottom_q <= bottom_n;
				found_q  <= found_n;
				clr_q    <= clr_q || in_data.new_set;
			end
		end
	end

endmodule

// File: rtl/inkbb_fifo.sv
`timescale 1ns / 1ps
module inkbb_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  inkbb_pkg::page_rec_t wdata,
	output logic                 full,
	input  logic                 pop,
	output logic                 empty,
	output inkbb_pkg::page_rec_t rdata
);
	import inkbb_pkg::*;

	page_rec_t        mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wptr_q, rptr_q;
	logic [FIFO_AW:0]   count_q;

	assign full  = count_q == (FIFO_AW+1)'(FIFO_DEPTH);
	assign empty = count_q == '0;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop)  rptr_q <= rptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/inkbb_back.sv
`timescale 1ns / 1ps
module inkbb_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fifo_empty,
	input  inkbb_pkg::page_rec_t fifo_rdata,
	output logic                 fifo_pop,
	input  inkbb_pkg::geom_t     geom,
	input  inkbb_pkg::cfg_t      cfg,
	output logic                 out_valid,
	input  logic                 out_stall,
	output inkbb_pkg::out_t      out_data
);
	import inkbb_pkg::*;

	logic                en;
	logic                v1_s1, v2_s2, v3_s3, out_valid_q;
	logic                clr_s1, clr_s2, clr_s3;
	logic                fnd_s1, fnd_s2, fnd_s3;
	logic [DIST_W-1:0]   dist_s1 [LANES];
	logic [VAL_W-1:0]    val_s2  [LANES];
	logic [MARGIN_W-1:0] mar_s3  [LANES];
	logic [MARGIN_W-1:0] com_q   [LANES];
	logic                seen_q;
	out_t                out_q;

	logic [DIST_W-1:0]   dist_c  [LANES];
	logic [SCALE_W-1:0]  scale_c [LANES];
	logic [PROD_W-1:0]   prod_c  [LANES];
	logic [MARGIN_W-1:0] mar_c   [LANES];
	logic [VAL_W-1:0]    diff_c  [LANES];
	logic [MARGIN_W-1:0] base_c  [LANES];
	logic [MARGIN_W-1:0] com_c   [LANES];
	logic                seen_b, seen_c, nz_c;

	assign en       = !out_valid_q || !out_stall;
	assign fifo_pop = en && !fifo_empty;

	// blank distances per side: left, right, top, bottom
	always_comb begin
		dist_c[0] = DIST_W'(fifo_rdata.left);
		dist_c[1] = (fifo_rdata.right < geom.wm1) ?
		            DIST_W'(geom.wm1 - fifo_rdata.right) : '0;
		dist_c[2] = DIST_W'(fifo_rdata.top);
		dist_c[3] = (fifo_rdata.bottom < geom.hm1) ?
		            DIST_W'(geom.hm1 - fifo_rdata.bottom) : '0;
		scale_c[0] = cfg.scale_x;
		scale_c[1] = cfg.scale_x;
		scale_c[2] = cfg.scale_y;
		scale_c[3] = cfg.scale_y;
	end

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			prod_c[i] = PROD_W'(dist_s1[i]) * PROD_W'(scale_c[i]);
			diff_c[i] = val_s2[i] - VAL_W'(cfg.keep_margin);
			if (val_s2[i] <= VAL_W'(cfg.keep_margin)) begin
				mar_c[i] = '0;
			end else if (diff_c[i] > VAL_W'(MARGIN_MAX)) begin
				mar_c[i] = MARGIN_MAX;
			end else begin
				mar_c[i] = diff_c[i][MARGIN_W-1:0];
			end
			if (!fnd_s2) mar_c[i] = '0;
		end
	end

	// running per-side minimum over the set
	always_comb begin
		seen_b = seen_q && !clr_s3;
		nz_c   = 1'b0;
		for (int i = 0; i < LANES; i++) begin
			base_c[i] = clr_s3 ? '0 : com_q[i];
			nz_c      = nz_c || (mar_s3[i] != '0);
		end
		for (int i = 0; i < LANES; i++) begin
			com_c[i] = base_c[i];
			if (nz_c && (!seen_b || mar_s3[i] < base_c[i])) com_c[i] = mar_s3[i];
		end
		seen_c = seen_b || nz_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			clr_s1 <= fifo_rdata.clear;
			fnd_s1 <= fifo_rdata.ink_found;
			clr_s2 <= clr_s1;
			fnd_s2 <= fnd_s1;
			clr_s3 <= clr_s2;
			fnd_s3 <= fnd_s2;
			for (int i = 0; i < LANES; i++) begin
				dist_s1[i] <= dist_c[i];
				val_s2[i]  <= prod_c[i][PROD_W-1:FRAC_SHIFT];
				mar_s3[i]  <= mar_c[i];
			end
			out_q.margin_left   <= mar_s3[0];
			out_q.margin_right  <= mar_s3[1];
			out_q.margin_top    <= mar_s3[2];
			out_q.margin_bottom <= mar_s3[3];
			out_q.blank_page    <= !fnd_s3;
			out_q.common_left   <= com_c[0];
			out_q.common_right  <= com_c[1];
			out_q.common_top    <= com_c[2];
			out_q.common_bottom <= com_c[3];
			out_q.common_valid  <= seen_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1       <= 1'b0;
			v2_s2       <= 1'b0;
			v3_s3       <= 1'b0;
			out_valid_q <= 1'b0;
			seen_q      <= 1'b0;
			for (int i = 0; i < LANES; i++) com_q[i] <= '0;
		end else if (en) begin
			v1_s1       <= !fifo_empty;
			v2_s2       <= v1_s1;
			v3_s3       <= v2_s2;
			out_valid_q <= v3_s3;
			if (v3_s3) begin
				seen_q <= seen_c;
				for (int i = 0; i < LANES; i++) com_q[i] <= com_c[i];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: rtl/ink_bbox_margin_detector.sv
`timescale 1ns / 1ps
// Ink bounding-box margin detector. Takes one 8-bit grey pixel per cycle when not
// stalled, in raster order, and tracks the ink bounding box; each page result leaves
// through a four-stage back pipeline (distance, Q12.12 multiply, keep-margin clamp,
// set minimum). Page records wait in a four-entry queue between the pixel scanner
// and that pipeline, so the input stalls only while the queue is full, which happens
// when the output has been stalled long enough; with the output free the block
// sustains one pixel per cycle even for one-pixel pages.
module ink_bbox_margin_detector (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  inkbb_pkg::in_t                       in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output inkbb_pkg::out_t                      out_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [inkbb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [inkbb_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import inkbb_pkg::*;

	cfg_t      cfg_q;
	geom_t     geom;
	page_rec_t wrec, rrec;
	logic      push, pop, full, empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dark_threshold <= THR_W'(128);
			cfg_q.image_width    <= DIM_W'(4096);
			cfg_q.image_height   <= DIM_W'(4096);
			cfg_q.scale_x        <= SCALE_W'(65536);
			cfg_q.scale_y        <= SCALE_W'(65536);
			cfg_q.keep_margin    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DARK_THRESHOLD: cfg_q.dark_threshold <= cfg_data[THR_W-1:0];
				CFG_IMAGE_WIDTH:    cfg_q.image_width    <= cfg_data[DIM_W-1:0];
				CFG_IMAGE_HEIGHT:   cfg_q.image_height   <= cfg_data[DIM_W-1:0];
				CFG_SCALE_X:        cfg_q.scale_x        <= cfg_data[SCALE_W-1:0];
				CFG_SCALE_Y:        cfg_q.scale_y        <= cfg_data[SCALE_W-1:0];
				CFG_KEEP_MARGIN:    cfg_q.keep_margin    <= cfg_data[MARGIN_W-1:0];
				default:            cfg_q                <= cfg_q;
			endcase
		end
	end

	inkbb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.cfg       (cfg_q),
		.fifo_full (full),
		.push      (push),
		.rec       (wrec),
		.geom      (geom)
	);

	inkbb_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wrec),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.rdata  (rrec)
	);

	inkbb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_empty (empty),
		.fifo_rdata (rrec),
		.fifo_pop   (pop),
		.geom       (geom),
		.cfg        (cfg_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

// File: rtl/inkbb_checker.sv
`timescale 1ns / 1ps
module inkbb_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            out_valid,
	input logic            out_stall,
	input inkbb_pkg::out_t out_data
);
	import inkbb_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// blank page gives zero trims
	a_blank_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.blank_page |->
			out_data.margin_left == '0 && out_data.margin_right == '0 &&
			out_data.margin_top == '0 && out_data.margin_bottom == '0)
		else $error("blank page with nonzero trim");

	// common minimum not yet seen reads as zero
	a_common_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.common_valid |->
			out_data.common_left == '0 && out_data.common_right == '0 &&
			out_data.common_top == '0 && out_data.common_bottom == '0)
		else $error("common margins set without a contributing page");

	// a contributing page bounds the common minimum
	a_common_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.margin_left != '0 || out_data.margin_right != '0 ||
			out_data.margin_top != '0 || out_data.margin_bottom != '0) |->
			out_data.common_valid &&
			out_data.common_left <= out_data.margin_left &&
			out_data.common_right <= out_data.margin_right &&
			out_data.common_top <= out_data.margin_top &&
			out_data.common_bottom <= out_data.margin_bottom)
		else $error("common margin above page trim");

endmodule

bind ink_bbox_margin_detector inkbb_checker u_inkbb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

// File: tb/tb_ink_bbox_margin_detector.sv
`timescale 1ns / 1ps
module tb_ink_bbox_margin_detector;
	import inkbb_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_t                   in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_t                  out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ink_bbox_margin_detector DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow registers
	logic [THR_W-1:0]    thr_reg;
	logic [DIM_W-1:0]    width_reg;
	logic [DIM_W-1:0]    height_reg;
	logic [SCALE_W-1:0]  scale_x_reg;
	logic [SCALE_W-1:0]  scale_y_reg;
	logic [MARGIN_W-1:0] keep_reg;

	// scanner model state
	int unsigned         scan_col;
	int unsigned         scan_row;
	int unsigned         box_left;
	int unsigned         box_right;
	int unsigned         box_top;
	int unsigned         box_bottom;
	bit                  box_found;
	logic [MARGIN_W-1:0] set_trim [4];
	bit                  set_seen;

	out_t pending_pages [$];

	int errors;
	int cycle_count;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;

	always #5 clk = ~clk;

	function automatic int unsigned eff_dim(logic [DIM_W-1:0] r, int unsigned cap);
		if (r == 0)
			return 1;
		return (r > cap) ? cap : r;
	endfunction

	function automatic logic [MARGIN_W-1:0] to_trim(int unsigned px, logic [SCALE_W-1:0] sc);
		logic [63:0] v;
		v = (64'(px) * 64'(sc)) >> FRAC_SHIFT;
		if (v <= 64'(keep_reg))
			return '0;
		v = v - 64'(keep_reg);
		return (v > 64'(MARGIN_MAX)) ? MARGIN_MAX : v[MARGIN_W-1:0];
	endfunction

	task automatic scan_pixel(in_t px);
		int unsigned w;
		int unsigned h;
		logic [MARGIN_W-1:0] m [4];
		bit page_end;
		out_t r;
		w = eff_dim(width_reg, MAX_WIDTH);
		h = eff_dim(height_reg, MAX_HEIGHT);
		if (px.new_set) begin
			for (int i = 0; i < 4; i++)
				set_trim[i] = '0;
			set_seen = 0;
		end
		if ({1'b0, px.grey} < thr_reg) begin
			if (!box_found) begin
				box_left = scan_col;
				box_right = scan_col;
				box_top = scan_row;
				box_bottom = scan_row;
				box_found = 1;
			end else begin
				if (scan_col < box_left) box_left = scan_col;
				if (scan_col > box_right) box_right = scan_col;
				if (scan_row < box_top) box_top = scan_row;
				if (scan_row > box_bottom) box_bottom = scan_row;
			end
		end
		page_end = 0;
		if (scan_col >= w - 1) begin
			scan_col = 0;
			if (scan_row >= h - 1) begin
				scan_row = 0;
				page_end = 1;
			end else begin
				scan_row++;
			end
		end else begin
			scan_col++;
		end
		if (!page_end)
			return;
		for (int i = 0; i < 4; i++)
			m[i] = '0;
		if (box_found) begin
			m[0] = to_trim(box_left, scale_x_reg);
			m[1] = to_trim((box_right < w - 1) ? w - 1 - box_right : 0, scale_x_reg);
			m[2] = to_trim(box_top, scale_y_reg);
			m[3] = to_trim((box_bottom < h - 1) ? h - 1 - box_bottom : 0, scale_y_reg);
			if ((m[0] | m[1] | m[2] | m[3]) != 0) begin
				for (int i = 0; i < 4; i++)
					if (!set_seen || m[i] < set_trim[i])
						set_trim[i] = m[i];
				set_seen = 1;
			end
		end
		r.margin_left = m[0];
		r.margin_right = m[1];
		r.margin_top = m[2];
		r.margin_bottom = m[3];
		r.blank_page = !box_found;
		r.common_left = set_trim[0];
		r.common_right = set_trim[1];
		r.common_top = set_trim[2];
		r.common_bottom = set_trim[3];
		r.common_valid = set_seen;
		pending_pages.push_back(r);
		box_found = 0;
		box_left = 0;
		box_right = 0;
		box_top = 0;
		box_bottom = 0;
	endtask

	always @(posedge clk)
		if (arst_n && in_valid && !in_stall)
			scan_pixel(in_data);

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s expected %0d actual %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin : check_beat
			out_t want;
			if (pending_pages.size() == 0) begin
				$error("result beat with no page pending");
				errors++;
			end else begin
				want = pending_pages.pop_front();
				check_field("margin_left", want.margin_left, out_data.margin_left);
				check_field("margin_right", want.margin_right, out_data.margin_right);
				check_field("margin_top", want.margin_top, out_data.margin_top);
				check_field("margin_bottom", want.margin_bottom, out_data.margin_bottom);
				check_field("blank_page", want.blank_page, out_data.blank_page);
				check_field("common_left", want.common_left, out_data.common_left);
				check_field("common_right", want.common_right, out_data.common_right);
				check_field("common_top", want.common_top, out_data.common_top);
				check_field("common_bottom", want.common_bottom, out_data.common_bottom);
				check_field("common_valid", want.common_valid, out_data.common_valid);
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else begin
			out_stall = ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_pixel(logic [7:0] g, logic ns);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data.grey = g;
		in_data.new_set = ns;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// stop offering pixels, let every page result and in-flight pixel clear
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_pages.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_DARK_THRESHOLD: thr_reg = v[THR_W-1:0];
			CFG_IMAGE_WIDTH:    width_reg = v[DIM_W-1:0];
			CFG_IMAGE_HEIGHT:   height_reg = v[DIM_W-1:0];
			CFG_SCALE_X:        scale_x_reg = v[SCALE_W-1:0];
			CFG_SCALE_Y:        scale_y_reg = v[SCALE_W-1:0];
			CFG_KEEP_MARGIN:    keep_reg = v[MARGIN_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [7:0] pick_grey(bit dark);
		if (dark && thr_reg > 0)
			return 8'($urandom_range(0, (thr_reg > 256) ? 255 : thr_reg - 1));
		if (!dark && thr_reg <= 255)
			return 8'($urandom_range(thr_reg, 255));
		return 8'($urandom_range(0, 255));
	endfunction

	// one page in raster order; optionally a set restart at its first pixel or somewhere inside it
	task automatic send_page(int ink_pct, bit ns_first, bit noise, output int sent);
		int unsigned count;
		int unsigned mid;
		bit ns;
		count = eff_dim(width_reg, MAX_WIDTH) * eff_dim(height_reg, MAX_HEIGHT);
		mid = (noise && count > 1) ? $urandom_range(1, count - 1) : 0;
		for (int unsigned i = 0; i < count; i++) begin
			ns = (i == 0) ? ns_first : (i == mid);
			send_pixel(pick_grey($urandom_range(0, 99) < ink_pct), ns);
		end
		sent = count;
	endtask

	task automatic test_basic_pages();
		write_reg(CFG_DARK_THRESHOLD, 128);
		write_reg(CFG_IMAGE_WIDTH, 3);
		write_reg(CFG_IMAGE_HEIGHT, 2);
		write_reg(CFG_SCALE_X, 65536);
		write_reg(CFG_SCALE_Y, 65536);
		write_reg(CFG_KEEP_MARGIN, 0);
		// single ink pixel, set opens here
		send_pixel(8'd255, 1'b1);
		send_pixel(8'd0, 1'b0);
		repeat (4) send_pixel(8'd255, 1'b0);
		// blank page
		repeat (6) send_pixel(8'd255, 1'b0);
		// full ink, all margins zero
		repeat (6) send_pixel(8'd0, 1'b0);
	endtask

	task automatic test_tiny_and_split_pages();
		settle();
		write_reg(CFG_IMAGE_WIDTH, 0);
		write_reg(CFG_IMAGE_HEIGHT, 0);
		// one-pixel page that restarts the set, common not valid
		send_pixel(8'd0, 1'b1);
		settle();
		write_reg(CFG_IMAGE_WIDTH, 2);
		write_reg(CFG_IMAGE_HEIGHT, 1);
		// set restart inside a page
		send_pixel(8'd200, 1'b0);
		send_pixel(8'd100, 1'b1);
		settle();
		write_reg(CFG_IMAGE_WIDTH, 3);
		write_reg(CFG_IMAGE_HEIGHT, 2);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd0, 1'b0);
		// narrow the page while it is partly scanned
		settle();
		write_reg(CFG_IMAGE_WIDTH, 2);
		repeat (3) send_pixel(8'd255, 1'b0);
	endtask

	task automatic test_backpressure();
		int saved;
		settle();
		write_reg(CFG_IMAGE_WIDTH, 1);
		write_reg(CFG_IMAGE_HEIGHT, 1);
		saved = send_idle_pct;
		send_idle_pct = 0;
		hold_left = 300;
		for (int i = 0; i < 30; i++)
			send_pixel(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		send_idle_pct = saved;
	endtask

	task automatic randomize_setup();
		logic [CFG_DATA_W-1:0] v;
		case ($urandom_range(0, 4))
			0: v = 0;
			1: v = 256;
			2: v = 128;
			default: v = CFG_DATA_W'($urandom_range(1, 255));
		endcase
		write_reg(CFG_DARK_THRESHOLD, v);
		for (int k = 0; k < 2; k++) begin
			case ($urandom_range(0, 9))
				0: v = 0;
				1: v = CFG_DATA_W'($urandom_range(9, 20));
				default: v = CFG_DATA_W'($urandom_range(1, (k == 0) ? 8 : 6));
			endcase
			if (k == 0)
				write_reg(CFG_IMAGE_WIDTH, v);
			else
				write_reg(CFG_IMAGE_HEIGHT, v);
		end
		for (int k = 0; k < 2; k++) begin
			case ($urandom_range(0, 5))
				0: v = 0;
				1: v = 24'hFFFFFF;
				2: v = 65536;
				3: v = CFG_DATA_W'($urandom_range(0, 24'hFFFFFF));
				default: v = CFG_DATA_W'($urandom_range(16384, 131072));
			endcase
			if (k == 0)
				write_reg(CFG_SCALE_X, v);
			else
				write_reg(CFG_SCALE_Y, v);
		end
		case ($urandom_range(0, 5))
			0: v = 0;
			1: v = 262143;
			2: v = CFG_DATA_W'($urandom_range(0, 262143));
			default: v = CFG_DATA_W'($urandom_range(0, 64));
		endcase
		write_reg(CFG_KEEP_MARGIN, v);
	endtask

	task automatic test_random_pages(int s_pct, int r_pct);
		int pixels;
		int pages;
		int sent;
		int ink_pct;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		pixels = 0;
		pages = 0;
		settle();
		randomize_setup();
		while (pixels < 50 || pages < 4) begin
			if ($urandom_range(0, 2) == 0) begin
				settle();
				randomize_setup();
			end
			case ($urandom_range(0, 5))
				0: ink_pct = 0;
				1: ink_pct = 100;
				2: ink_pct = 50;
				3: ink_pct = 20;
				default: ink_pct = 8;
			endcase
			send_page(ink_pct, $urandom_range(0, 3) == 0, $urandom_range(0, 9) == 0, sent);
			pixels += sent;
			pages++;
		end
	endtask

	task automatic test_extreme_geometry();
		settle();
		write_reg(CFG_DARK_THRESHOLD, 128);
		write_reg(CFG_KEEP_MARGIN, 0);
		write_reg(CFG_IMAGE_WIDTH, 80);
		write_reg(CFG_IMAGE_HEIGHT, 1);
		write_reg(CFG_SCALE_X, 24'hFFFFFF);
		// left trim saturates
		for (int i = 0; i < 80; i++)
			send_pixel((i == 70) ? 8'd0 : 8'd255, i == 0);
		settle();
		write_reg(CFG_IMAGE_WIDTH, 1);
		write_reg(CFG_IMAGE_HEIGHT, 70);
		write_reg(CFG_SCALE_Y, 24'hFFFFFF);
		write_reg(CFG_KEEP_MARGIN, 100);
		// bottom trim saturates after the keep margin
		for (int i = 0; i < 70; i++)
			send_pixel((i == 3) ? 8'd0 : 8'd255, 1'b0);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		cycle_count = 0;
		hold_left = 0;
		send_idle_pct = 34;
		recv_idle_pct = 67;
		thr_reg = 128;
		width_reg = 4096;
		height_reg = 4096;
		scale_x_reg = 65536;
		scale_y_reg = 65536;
		keep_reg = 0;
		scan_col = 0;
		scan_row = 0;
		box_left = 0;
		box_right = 0;
		box_top = 0;
		box_bottom = 0;
		box_found = 0;
		for (int i = 0; i < 4; i++)
			set_trim[i] = '0;
		set_seen = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_basic_pages();
		test_tiny_and_split_pages();
		test_backpressure();
		test_random_pages(34, 67);
		test_random_pages(67, 34);
		test_random_pages(0, 0);
		test_extreme_geometry();

		settle();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
